// ===== hw/rtl/c39_pkg.sv =====
// Package with the item types, codes and the symbol table of the edge-timing barcode decoder.
`timescale 1ns / 1ps
`default_nettype none
package c39_pkg;

    // Geometry of one symbol and of one frame.
    localparam int ELEMENTS_PER_SYMBOL = 9;
    localparam int MAX_CHARS           = 19;
    localparam int SYM_COUNT           = 11;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int CHARS_W = 5;
    localparam int ELEM_W  = 4;
    localparam int PAT_W   = 9;
    localparam int SYM_W   = 4;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_NARROW_MIN = 3'd0,
        CFG_NARROW_MAX = 3'd1,
        CFG_WIDE_MIN   = 3'd2,
        CFG_WIDE_MAX   = 3'd3,
        CFG_QUIET      = 3'd4,
        CFG_COOLDOWN   = 3'd5
    } cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] NARROW_MIN_RST = 16'd20;
    localparam logic [CFG_W-1:0] NARROW_MAX_RST = 16'd80;
    localparam logic [CFG_W-1:0] WIDE_MIN_RST   = 16'd80;
    localparam logic [CFG_W-1:0] WIDE_MAX_RST   = 16'd200;
    localparam logic [CFG_W-1:0] QUIET_RST      = 16'd500;
    localparam logic [CFG_W-1:0] COOLDOWN_RST   = 16'd1000;

    // Decoder modes as seen on the result.
    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_DETECT = 2'd1,
        MODE_COOL   = 2'd2
    } mode_t;

    // Held turn commands.
    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_LEFT    = 3'd1,
        CMD_RIGHT   = 3'd2,
        CMD_STOP    = 3'd3,
        CMD_UNKNOWN = 3'd4
    } cmd_t;

    // Symbol table indexes with a special meaning.
    localparam logic [SYM_W-1:0] SYM_STAR = 4'd0;
    localparam logic [SYM_W-1:0] SYM_L    = 4'd1;
    localparam logic [SYM_W-1:0] SYM_R    = 4'd2;
    localparam logic [SYM_W-1:0] SYM_S    = 4'd3;
    localparam logic [SYM_W-1:0] SYM_NONE = 4'd11;

    // Narrow/wide patterns, first element in the top bit.
    localparam logic [PAT_W-1:0] SYMBOL_PATTERN [SYM_COUNT] = '{
        9'h12D, 9'h153, 9'h14B, 9'h195, 9'h14D, 9'h1A5,
        9'h165, 9'h1B4, 9'h14E, 9'h1A6, 9'h166
    };

    // Configuration register file as one group.
    typedef struct packed {
        logic [CFG_W-1:0] narrow_min_ms;
        logic [CFG_W-1:0] narrow_max_ms;
        logic [CFG_W-1:0] wide_min_ms;
        logic [CFG_W-1:0] wide_max_ms;
        logic [CFG_W-1:0] quiet_timeout_ms;
        logic [CFG_W-1:0] cooldown_ms;
    } cfg_t;

    // One input item: a sensor sample.
    typedef struct packed {
        logic [TIME_W-1:0] time_ms;
        logic              sensor_black;
    } item_t;

    // One result item.
    typedef struct packed {
        logic [2:0]         turn_command;
        logic [1:0]         decoder_mode;
        logic [CHARS_W-1:0] chars_held;
    } result_t;

    // Classification of one element width.
    typedef struct packed {
        logic too_short;
        logic wide;
        logic invalid;
    } elem_class_t;

    // Table lookup: the first matching entry wins, SYM_NONE when none matches.
    function automatic logic [SYM_W-1:0] match_symbol(input logic [PAT_W-1:0] bits);
        logic [SYM_W-1:0] sym;
        sym = SYM_NONE;
        for (int i = SYM_COUNT - 1; i >= 0; i--) begin
            if (SYMBOL_PATTERN[i] == bits) begin
                sym = SYM_W'(i);
            end
        end
        return sym;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/c39_elem_class.sv =====
// Width classification of one bar or space element against the configured limits.
`timescale 1ns / 1ps
`default_nettype none
module c39_elem_class
    import c39_pkg::*;
(
    input  wire logic [TIME_W-1:0] width,
    input  wire cfg_t              cfg,
    output elem_class_t            cls
);

    logic is_narrow;
    logic is_wide;

    // Narrow is tested first, so overlapping ranges resolve to narrow.
    assign is_narrow = (width >= TIME_W'(cfg.narrow_min_ms))
                     && (width <= TIME_W'(cfg.narrow_max_ms));
    assign is_wide   = (width >= TIME_W'(cfg.wide_min_ms))
                     && (width <= TIME_W'(cfg.wide_max_ms));

    assign cls.too_short = width < TIME_W'(cfg.narrow_min_ms);
    assign cls.wide      = !is_narrow && is_wide;
    assign cls.invalid   = !is_narrow && !is_wide;

endmodule
`default_nettype wire

// ===== hw/rtl/c39_frame_ctrl.sv =====
// Decoder state: element assembly, symbol lookup, frame tracking, timeouts and command.
`timescale 1ns / 1ps
`default_nettype none
module c39_frame_ctrl
    import c39_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  step,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    result_next
);

    mode_t              mode_reg, mode_next;
    logic [TIME_W-1:0]  last_edge_reg, last_edge_next;
    logic               last_level_reg;
    logic [ELEM_W-1:0]  elem_count_reg, elem_count_next;
    logic [PAT_W-1:0]   pattern_reg, pattern_next;
    logic               bad_reg, bad_next;
    logic [CHARS_W-1:0] chars_reg, chars_next;
    logic [SYM_W-1:0]   first_reg, first_next;
    logic [SYM_W-1:0]   second_reg, second_next;
    logic [SYM_W-1:0]   final_reg, final_next;
    cmd_t               cmd_reg, cmd_next;

    logic [TIME_W-1:0]  width;
    logic               edge_seen;
    elem_class_t        cls;
    logic [PAT_W-1:0]   pattern_shift;
    logic               bad_shift;
    logic [SYM_W-1:0]   sym;
    logic               complete;

    // Time since the last recorded edge, modulo 2^32.
    assign width     = item.time_ms - last_edge_reg;
    assign edge_seen = item.sensor_black != last_level_reg;

    c39_elem_class u_class (
        .width (width),
        .cfg   (cfg),
        .cls   (cls)
    );

    // Pattern after this element and the symbol it would close.
    assign pattern_shift = {pattern_reg[PAT_W-2:0], cls.wide};
    assign bad_shift     = bad_reg | cls.invalid;
    assign sym           = bad_shift ? SYM_NONE : match_symbol(pattern_shift);

    // Next state of the decoder for one sample.
    always_comb
    begin
        mode_next       = mode_reg;
        last_edge_next  = last_edge_reg;
        elem_count_next = elem_count_reg;
        pattern_next    = pattern_reg;
        bad_next        = bad_reg;
        chars_next      = chars_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        final_next      = final_reg;
        cmd_next        = cmd_reg;
        complete        = 1'b0;

        // Edges start a frame in idle and deliver elements while detecting.
        if (edge_seen && mode_reg == MODE_IDLE) begin
            mode_next       = MODE_DETECT;
            elem_count_next = '0;
            pattern_next    = '0;
            bad_next        = 1'b0;
            chars_next      = '0;
            last_edge_next  = item.time_ms;
        end else if (edge_seen && mode_reg == MODE_DETECT) begin
            last_edge_next = item.time_ms;
            if (!cls.too_short) begin
                if (elem_count_reg == ELEM_W'(ELEMENTS_PER_SYMBOL - 1)) begin
                    elem_count_next = '0;
                    pattern_next    = '0;
                    bad_next        = 1'b0;
                    if (sym == SYM_NONE) begin
                        mode_next = MODE_IDLE;
                    end else begin
                        if (chars_reg < CHARS_W'(MAX_CHARS)) begin
                            if (chars_reg == CHARS_W'(0)) begin
                                first_next = sym;
                            end
                            if (chars_reg == CHARS_W'(1)) begin
                                second_next = sym;
                            end
                            final_next = sym;
                            chars_next = chars_reg + CHARS_W'(1);
                        end
                        if (sym == SYM_STAR && chars_reg != '0) begin
                            complete = 1'b1;
                        end
                    end
                end else begin
                    elem_count_next = elem_count_reg + ELEM_W'(1);
                    pattern_next    = pattern_shift;
                    bad_next        = bad_shift;
                end
            end
        end

        // Quiet gap while detecting: only possible without an edge in this sample.
        if (mode_reg == MODE_DETECT && !edge_seen
            && width > TIME_W'(cfg.quiet_timeout_ms)) begin
            if (chars_reg != '0 && final_reg == SYM_STAR) begin
                complete = 1'b1;
            end else begin
                mode_next = MODE_IDLE;
            end
        end

        // Frame completion resolves the held command and starts the cooldown.
        if (complete) begin
            mode_next      = MODE_COOL;
            last_edge_next = item.time_ms;
            if (chars_next < CHARS_W'(3) || first_next != SYM_STAR
                || final_next != SYM_STAR) begin
                cmd_next = CMD_UNKNOWN;
            end else if (second_next == SYM_L) begin
                cmd_next = CMD_LEFT;
            end else if (second_next == SYM_R) begin
                cmd_next = CMD_RIGHT;
            end else if (second_next == SYM_S) begin
                cmd_next = CMD_STOP;
            end else begin
                cmd_next = CMD_UNKNOWN;
            end
        end

        // Cooldown ends once the time since the decode exceeds its limit.
        if (mode_reg == MODE_COOL && width > TIME_W'(cfg.cooldown_ms)) begin
            mode_next = MODE_IDLE;
        end
    end

    assign result_next.turn_command = cmd_next;
    assign result_next.decoder_mode = mode_next;
    assign result_next.chars_held   = chars_next;

    // State registers advance once per item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= MODE_IDLE;
            last_edge_reg  <= '0;
            last_level_reg <= 1'b0;
            elem_count_reg <= '0;
            pattern_reg    <= '0;
            bad_reg        <= 1'b0;
            chars_reg      <= '0;
            first_reg      <= '0;
            second_reg     <= '0;
            final_reg      <= '0;
            cmd_reg        <= CMD_NONE;
        end else if (step) begin
            mode_reg       <= mode_next;
            last_edge_reg  <= last_edge_next;
            last_level_reg <= item.sensor_black;
            elem_count_reg <= elem_count_next;
            pattern_reg    <= pattern_next;
            bad_reg        <= bad_next;
            chars_reg      <= chars_next;
            first_reg      <= first_next;
            second_reg     <= second_next;
            final_reg      <= final_next;
            cmd_reg        <= cmd_next;
        end
    end

endmodule
`default_nettype wire

// ===== hw/rtl/code39_edge_timing_decoder_core.sv =====
// Top level of the edge-timing barcode decoder: ports, configuration and item stages.
//
//   Channel  | Direction | Handshake                    | Payload
//   ---------+-----------+------------------------------+-------------------------------
//   item     | in        | item_valid / item_stall      | item_t: time_ms, sensor_black
//   result   | out       | result_valid / result_stall  | result_t: command, mode, chars
//   config   | in        | cfg_we                       | cfg_index, cfg_data (16 bits)
//
// Each item is captured in the input register and is then resolved into the result
// register, where the decoder state is updated too; while the result is not stalled,
// one item per cycle is sustained. A stalled result holds both stages, so item_stall rises
// only when both registers are full. Reset clears the decoder state and loads the
// configuration defaults; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module code39_edge_timing_decoder_core
    import c39_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire item_t      item,
    output logic            result_valid,
    input  wire logic       result_stall,
    output result_t         result,
    input  wire logic       cfg_we,
    input  wire logic [2:0] cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    cfg_t    cfg_reg;
    logic    stage_valid_reg;
    item_t   stage_item_reg;
    logic    result_valid_reg;
    result_t result_reg;
    result_t result_next;
    logic    advance;
    logic    take_item;

    // Configuration register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.narrow_min_ms    <= NARROW_MIN_RST;
            cfg_reg.narrow_max_ms    <= NARROW_MAX_RST;
            cfg_reg.wide_min_ms      <= WIDE_MIN_RST;
            cfg_reg.wide_max_ms      <= WIDE_MAX_RST;
            cfg_reg.quiet_timeout_ms <= QUIET_RST;
            cfg_reg.cooldown_ms      <= COOLDOWN_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_NARROW_MIN: cfg_reg.narrow_min_ms    <= cfg_data;
                CFG_NARROW_MAX: cfg_reg.narrow_max_ms    <= cfg_data;
                CFG_WIDE_MIN:   cfg_reg.wide_min_ms      <= cfg_data;
                CFG_WIDE_MAX:   cfg_reg.wide_max_ms      <= cfg_data;
                CFG_QUIET:      cfg_reg.quiet_timeout_ms <= cfg_data;
                CFG_COOLDOWN:   cfg_reg.cooldown_ms      <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Handshake between the input register and the result register.
    assign advance    = stage_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = stage_valid_reg && !advance;
    assign take_item  = item_valid && !item_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
        end else if (take_item) begin
            stage_valid_reg <= 1'b1;
        end else if (advance) begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_item) begin
            stage_item_reg <= item;
        end
    end

    c39_frame_ctrl u_frame (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (stage_item_reg),
        .cfg         (cfg_reg),
        .result_next (result_next)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            result_valid_reg <= 1'b0;
        end else if (advance) begin
            result_valid_reg <= 1'b1;
        end else if (!result_stall) begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/c39_checker.sv =====
// Port-level checks of the edge-timing barcode decoder and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module c39_checker
    import c39_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    result_valid,
    input wire logic    result_stall,
    input wire result_t result
);

    // A stalled result item holds its place and its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result item changed");

    // The character count never goes beyond the frame capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.chars_held <= CHARS_W'(MAX_CHARS))
    else $error("character count beyond frame capacity");

    // Only defined mode and command codes appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.decoder_mode != 2'd3 && result.turn_command <= CMD_UNKNOWN)
    else $error("undefined mode or command code");

    // Cooldown is only entered after a decode, which always leaves a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.decoder_mode == MODE_COOL |-> result.turn_command != CMD_NONE)
    else $error("cooldown without a held command");

endmodule

bind code39_edge_timing_decoder_core c39_checker u_c39_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
`default_nettype wire
